[sv/rwm_pkg.sv]
// Shared types and constants of the ring window min/max and time lookup block
`timescale 1ns / 1ps

package rwm_pkg;

   // Ring geometry and value widths
   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = SLOT_W + 1;
   localparam int VAL_W     = 32;
   localparam int ENTRY_W   = 3 * VAL_W;

   // Request codes
   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // Input transfer
   typedef struct packed {
      logic                    req_type;
      logic signed [VAL_W-1:0] entry_min;
      logic signed [VAL_W-1:0] entry_max;
      logic signed [VAL_W-1:0] entry_time;
      logic signed [VAL_W-1:0] query_time;
   } rwm_req_type;

   // Result transfer
   typedef struct packed {
      logic signed [VAL_W-1:0] window_min;
      logic signed [VAL_W-1:0] window_max;
      logic [CNT_W-1:0]        held_count;
      logic [SLOT_W-1:0]       nearest_age;
      logic                    ring_empty;
   } rwm_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic walk;
      logic finish;
   } rwm_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic walk_done;
   } rwm_status_type;

endpackage

[sv/rwm_ctrl.sv]
// Controller state machine: accepts a request, runs the slot walk, issues the result strobe
`timescale 1ns / 1ps

module rwm_ctrl
   import rwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output rwm_cmd_type    cmd,
   input  rwm_status_type status,
   output logic           rsp_valid
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // Commands decoded from the state
   assign cmd.load   = start && (state_ff == ST_IDLE);
   assign cmd.walk   = (state_ff == ST_WALK);
   assign cmd.finish = (state_ff == ST_WALK) && status.walk_done;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (status.walk_done) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[sv/rwm_datapath.sv]
// Datapath: slot memory, window extremes, ring pointers, slot walk and result register
`timescale 1ns / 1ps

module rwm_datapath
   import rwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rwm_req_type    req_payload,
   input  rwm_cmd_type    cmd,
   output rwm_status_type status,
   input  logic           csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output rwm_rsp_type    rsp_payload
);

   // Slot memory, one word of {min, max, time} per slot
   logic [ENTRY_W-1:0] mem [MAX_SLOTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Ring and window state
   logic [CNT_W-1:0]        win_size_ff, win_size_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [SLOT_W-1:0]       oldest_ff, oldest_in;
   logic signed [VAL_W-1:0] cur_min_ff, cur_min_in;
   logic signed [VAL_W-1:0] cur_max_ff, cur_max_in;
   logic [SLOT_W-1:0]       min_own_ff, min_own_in;
   logic [SLOT_W-1:0]       max_own_ff, max_own_in;

   // Walk control
   logic                    lookup_ff, lookup_in;
   logic                    rmin_ff, rmin_in;
   logic                    rmax_ff, rmax_in;
   logic [CNT_W-1:0]        len_ff, len_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic [SLOT_W-1:0]       addr_ff, addr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [SLOT_W-1:0]       rd_idx_ff, rd_idx_in;

   // Lookup working registers
   logic signed [VAL_W:0]   q2_ff, q2_in;
   logic signed [VAL_W-1:0] prev_ff, prev_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       age_ff, age_in;

   rwm_rsp_type             rsp_ff, rsp_in;

   // Combinational helpers
   logic                    full;
   logic [SLOT_W-1:0]       slot;
   logic                    took_min, took_max;
   logic                    mem_we, mem_re;
   logic signed [VAL_W-1:0] rd_min, rd_max, rd_time;
   logic signed [VAL_W:0]   pair_sum;
   logic [CNT_W-1:0]        csr_sat;
   logic                    empty;

   assign full     = (fill_ff >= win_size_ff);
   assign slot     = full ? oldest_ff : fill_ff[SLOT_W-1:0];
   assign took_min = req_payload.entry_min < cur_min_ff;
   assign took_max = req_payload.entry_max > cur_max_ff;
   assign mem_we   = cmd.load && (req_payload.req_type == REQ_ADD);
   assign mem_re   = cmd.walk && (iss_ff < len_ff);

   assign rd_min   = $signed(rd_data_ff[3*VAL_W-1:2*VAL_W]);
   assign rd_max   = $signed(rd_data_ff[2*VAL_W-1:VAL_W]);
   assign rd_time  = $signed(rd_data_ff[VAL_W-1:0]);
   assign pair_sum = {prev_ff[VAL_W-1], prev_ff} + {rd_time[VAL_W-1], rd_time};

   // Window size saturates to 1..MAX_SLOTS
   always_comb begin
      if (csr_wr_data == '0) begin
         csr_sat = CNT_W'(1);
      end else if (csr_wr_data > CNT_W'(MAX_SLOTS)) begin
         csr_sat = CNT_W'(MAX_SLOTS);
      end else begin
         csr_sat = csr_wr_data;
      end
   end

   assign empty = (fill_ff == '0);

   assign status.walk_done = (iss_ff == len_ff) && !rd_valid_ff;
   assign rsp_payload      = rsp_ff;

   // Next-state logic
   always_comb begin
      win_size_in = win_size_ff;
      fill_in     = fill_ff;
      oldest_in   = oldest_ff;
      cur_min_in  = cur_min_ff;
      cur_max_in  = cur_max_ff;
      min_own_in  = min_own_ff;
      max_own_in  = max_own_ff;
      lookup_in   = lookup_ff;
      rmin_in     = rmin_ff;
      rmax_in     = rmax_ff;
      len_in      = len_ff;
      iss_in      = iss_ff;
      addr_in     = addr_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      q2_in       = q2_ff;
      prev_in     = prev_ff;
      found_in    = found_ff;
      age_in      = age_ff;
      rsp_in      = rsp_ff;

      // Accepted request
      if (cmd.load) begin
         lookup_in = (req_payload.req_type == REQ_LOOKUP);
         rmin_in   = 1'b0;
         rmax_in   = 1'b0;
         iss_in    = '0;
         len_in    = '0;
         found_in  = 1'b0;
         age_in    = '0;
         q2_in     = {req_payload.query_time, 1'b0};
         if (req_payload.req_type == REQ_LOOKUP) begin
            // Walk from the oldest entry; one entry or none answers age 0
            addr_in = oldest_ff;
            if (fill_ff >= CNT_W'(2)) begin
               len_in = fill_ff;
            end else begin
               found_in = 1'b1;
            end
         end else begin
            addr_in = '0;
            if (empty) begin
               cur_min_in = req_payload.entry_min;
               cur_max_in = req_payload.entry_max;
               min_own_in = slot;
               max_own_in = slot;
               fill_in    = CNT_W'(1);
            end else begin
               if (took_min) begin
                  cur_min_in = req_payload.entry_min;
                  min_own_in = slot;
               end
               if (took_max) begin
                  cur_max_in = req_payload.entry_max;
                  max_own_in = slot;
               end
               if (full) begin
                  // Evicting an owner forces a rescan of all slots
                  rmin_in = (min_own_ff == slot) && !took_min;
                  rmax_in = (max_own_ff == slot) && !took_max;
                  if (((min_own_ff == slot) && !took_min) ||
                      ((max_own_ff == slot) && !took_max)) begin
                     len_in = fill_ff;
                  end
                  if ((CNT_W'(oldest_ff) + CNT_W'(1)) == win_size_ff) begin
                     oldest_in = '0;
                  end else begin
                     oldest_in = oldest_ff + SLOT_W'(1);
                  end
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
      end

      // Issue one slot read per cycle
      if (mem_re) begin
         rd_valid_in = 1'b1;
         rd_idx_in   = iss_ff[SLOT_W-1:0];
         iss_in      = iss_ff + CNT_W'(1);
         if ((CNT_W'(addr_ff) + CNT_W'(1)) == win_size_ff) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + SLOT_W'(1);
         end
      end

      // Consume returned slot data
      if (rd_valid_ff) begin
         if (lookup_ff) begin
            if ((rd_idx_ff != '0) && !found_ff && (q2_ff < pair_sum)) begin
               found_in = 1'b1;
               age_in   = rd_idx_ff - SLOT_W'(1);
            end
            prev_in = rd_time;
         end else begin
            if (rmin_ff && ((rd_idx_ff == '0) || (rd_min < cur_min_ff))) begin
               cur_min_in = rd_min;
               min_own_in = rd_idx_ff;
            end
            if (rmax_ff && ((rd_idx_ff == '0) || (rd_max > cur_max_ff))) begin
               cur_max_in = rd_max;
               max_own_in = rd_idx_ff;
            end
         end
      end

      // Result capture
      if (cmd.finish) begin
         rsp_in.window_min = empty ? '0 : cur_min_ff;
         rsp_in.window_max = empty ? '0 : cur_max_ff;
         rsp_in.held_count = fill_ff;
         rsp_in.ring_empty = empty;
         if (!lookup_ff) begin
            rsp_in.nearest_age = '0;
         end else if (found_ff) begin
            rsp_in.nearest_age = age_ff;
         end else begin
            rsp_in.nearest_age = SLOT_W'(fill_ff - CNT_W'(1));
         end
      end

      // Window size write empties the ring
      if (csr_wr_en) begin
         win_size_in = csr_sat;
         fill_in     = '0;
         oldest_in   = '0;
         cur_min_in  = '0;
         cur_max_in  = '0;
         min_own_in  = '0;
         max_own_in  = '0;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= CNT_W'(MAX_SLOTS);
         fill_ff     <= '0;
         oldest_ff   <= '0;
         cur_min_ff  <= '0;
         cur_max_ff  <= '0;
         min_own_ff  <= '0;
         max_own_ff  <= '0;
         len_ff      <= '0;
         iss_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         win_size_ff <= win_size_in;
         fill_ff     <= fill_in;
         oldest_ff   <= oldest_in;
         cur_min_ff  <= cur_min_in;
         cur_max_ff  <= cur_max_in;
         min_own_ff  <= min_own_in;
         max_own_ff  <= max_own_in;
         len_ff      <= len_in;
         iss_ff      <= iss_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      lookup_ff <= lookup_in;
      rmin_ff   <= rmin_in;
      rmax_ff   <= rmax_in;
      addr_ff   <= addr_in;
      rd_idx_ff <= rd_idx_in;
      q2_ff     <= q2_in;
      prev_ff   <= prev_in;
      found_ff  <= found_in;
      age_ff    <= age_in;
      rsp_ff    <= rsp_in;
   end

   // Slot memory: write on add, registered read during the walk
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot] <= {req_payload.entry_min, req_payload.entry_max,
                       req_payload.entry_time};
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

endmodule

[sv/ring_window_min_max_time_lookup.sv]
// Top level of the ring window min/max and time lookup block
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid, and must be captured then since
// the receiver cannot hold it off. An add whose new entry does not evict the
// owner of the window minimum or maximum answers without a slot walk. An add
// that evicts an owner rescans all held slots, and a lookup over n >= 2
// entries walks them oldest first; busy stays high through the walk and the
// result shows as busy falls. The walk is paced by the single read port of
// the 64-entry slot memory, one slot per cycle. A write on the csr port sets
// the window size (saturated to 1..64) and empties the ring; issue it only
// while the block is idle and no result is pending.

module ring_window_min_max_time_lookup
   import rwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rwm_req_type      req_payload,
   output logic             rsp_valid,
   output rwm_rsp_type      rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   rwm_cmd_type    cmd;
   rwm_status_type status;

   rwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid)
   );

   rwm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_payload (rsp_payload)
   );

   // A result transfer is only issued once the request has completed
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted request always occupies the block in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start");

   // An empty ring reports zero extremes and no entries
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.ring_empty) |->
         (rsp_payload.window_min == '0) && (rsp_payload.window_max == '0) &&
         (rsp_payload.held_count == '0) && (rsp_payload.nearest_age == '0))
      else $error("empty ring result not cleared");

   // Held count never exceeds the ring
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.held_count <= CNT_W'(MAX_SLOTS)))
      else $error("held count beyond ring size");

endmodule
